>>> design/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg: shared types and constants for the YUYV to RGB888 converter
// Fixed-point coefficient values, datapath widths, payload structs and the
// channel clamp used by both pixel datapaths.
// ----------------------------------------------------------------------------
package y2r_pkg;

    // Fraction bits of the fixed-point chroma coefficients (range 8..24).
    localparam int COEF_FRAC_BITS = 16;

    // Coefficients are below 2.0: one integer bit plus the fraction.
    localparam int COEF_W = COEF_FRAC_BITS + 1;
    // |k * (c - 128)| < 2^(F+8); one more bit for the sign.
    localparam int PROD_W = COEF_FRAC_BITS + 9;
    // Y * 2^F plus up to two chroma terms, signed.
    localparam int ACC_W  = COEF_FRAC_BITS + 10;

    localparam longint unsigned COEF_SCALE = 64'd1 << COEF_FRAC_BITS;

    // Round to nearest from thousandths.
    localparam longint unsigned K_RV_L = (64'd1402 * COEF_SCALE + 64'd500) / 64'd1000;
    localparam longint unsigned K_GU_L = (64'd344 * COEF_SCALE + 64'd500) / 64'd1000;
    localparam longint unsigned K_GV_L = (64'd714 * COEF_SCALE + 64'd500) / 64'd1000;
    localparam longint unsigned K_BU_L = (64'd1772 * COEF_SCALE + 64'd500) / 64'd1000;

    localparam logic [COEF_W-1:0] K_RV = K_RV_L[COEF_W-1:0];
    localparam logic [COEF_W-1:0] K_GU = K_GU_L[COEF_W-1:0];
    localparam logic [COEF_W-1:0] K_GV = K_GV_L[COEF_W-1:0];
    localparam logic [COEF_W-1:0] K_BU = K_BU_L[COEF_W-1:0];

    localparam logic signed [8:0] CHROMA_MID = 9'sd128;
    localparam logic [7:0]        CHAN_MAX   = 8'hFF;
    localparam logic [7:0]        CHAN_MIN   = 8'h00;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       frame_end_in;
    } y2r_yuv_t;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       frame_end_out;
    } y2r_rgb_t;

    // Load strobes for the per-pixel sum and clamp stages.
    typedef struct packed {
        logic sum_load;
        logic clamp_load;
    } y2r_adv_t;

    // Saturate a Q(F) accumulator to 0..255 after flooring the fraction.
    function automatic logic [7:0] y2r_clamp(input logic signed [ACC_W-1:0] acc);
        logic [7:0] res;
        priority if (acc[ACC_W-1])
            res = CHAN_MIN;
        else if (acc[ACC_W-2:COEF_FRAC_BITS+8] != '0)
            res = CHAN_MAX;
        else
            res = acc[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
        return res;
    endfunction

endpackage

>>> design/y2r_yuv_if.sv
// ----------------------------------------------------------------------------
// y2r_yuv_if: YUYV request channel
// Valid/ready channel carrying one YUYV word and the frame end flag.
// ----------------------------------------------------------------------------
interface y2r_yuv_if
    import y2r_pkg::*;
();
    logic     valid;
    logic     ready;
    y2r_yuv_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/y2r_rgb_if.sv
// ----------------------------------------------------------------------------
// y2r_rgb_if: RGB888 pair request channel
// Valid/ready channel carrying two RGB888 pixels and the frame end flag.
// ----------------------------------------------------------------------------
interface y2r_rgb_if
    import y2r_pkg::*;
();
    logic     valid;
    logic     ready;
    y2r_rgb_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/y2r_pixel.sv
// ----------------------------------------------------------------------------
// y2r_pixel: sum and clamp stages for one pixel
// Add the luma base to the shared chroma products, then floor and saturate
// each channel into its output register.
// ----------------------------------------------------------------------------
module y2r_pixel
    import y2r_pkg::*;
(
    input  logic                     clk,
    input  y2r_adv_t                 adv,
    input  logic [7:0]               luma,
    input  logic signed [PROD_W-1:0] prod_rv,
    input  logic signed [PROD_W-1:0] prod_gu,
    input  logic signed [PROD_W-1:0] prod_gv,
    input  logic signed [PROD_W-1:0] prod_bu,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue
);

    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] sum_r_next, sum_g_next, sum_b_next;
    logic signed [ACC_W-1:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic [7:0]              red_reg, green_reg, blue_reg;

    assign base = $signed({2'b00, luma, {COEF_FRAC_BITS{1'b0}}});

    always_comb
    begin
        sum_r_next = base + ACC_W'(prod_rv);
        sum_g_next = base - ACC_W'(prod_gu) - ACC_W'(prod_gv);
        sum_b_next = base + ACC_W'(prod_bu);
    end

    always_ff @(posedge clk)
    begin
        if (adv.sum_load)
        begin
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
        end
        if (adv.clamp_load)
        begin
            red_reg   <= y2r_clamp(sum_r_reg);
            green_reg <= y2r_clamp(sum_g_reg);
            blue_reg  <= y2r_clamp(sum_b_reg);
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

>>> design/yuyv_to_rgb24_converter.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb24_converter: YUYV 4:2:2 to RGB888, BT.601 full range
// Structure: four register stages, stage 4 being the output register.
// Throughput: one YUYV word per cycle while the output is not stalled,
//   two RGB888 pixels per result.
// Reset: rst_n (async, active low) clears all stage valid bits; the
//   datapath registers are not reset and the block is ready right away.
// ----------------------------------------------------------------------------
module yuyv_to_rgb24_converter
    import y2r_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    y2r_yuv_if.sink      yuv,
    y2r_rgb_if.source    rgb
);

    // Pipeline:
    //   stage 1  capture luma, center chroma around zero
    //   stage 2  four chroma products, shared by both pixels
    //   stage 3  per-pixel channel sums      (y2r_pixel)
    //   stage 4  floor and clamp to 0..255   (y2r_pixel, output register)
    // Each stage holds when it is full and the stage after it cannot take
    // its request; empty stages always load, so bubbles collapse.

    // Stage valid bits and their load enables.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    // Stage 1 payload.
    logic [7:0]        y0_s1_reg, y1_s1_reg;
    logic signed [8:0] u_s1_reg, v_s1_reg;
    logic signed [8:0] u_s1_next, v_s1_next;
    logic              fe_s1_reg;

    // Stage 2 payload.
    logic [7:0]               y0_s2_reg, y1_s2_reg;
    logic signed [PROD_W-1:0] prod_rv_reg, prod_gu_reg, prod_gv_reg, prod_bu_reg;
    logic signed [PROD_W-1:0] prod_rv_next, prod_gu_next, prod_gv_next, prod_bu_next;
    logic                     fe_s2_reg;

    // Frame end flag rides alongside stages 3 and 4.
    logic fe_s3_reg, fe_s4_reg;

    y2r_adv_t adv;

    // ------------------------------------------------------------------
    // Handshake: a stage may load when it is empty or its request moves on.
    // ------------------------------------------------------------------
    always_comb
    begin
        rdy4 = !v4_reg || rgb.ready;
        rdy3 = !v3_reg || rdy4;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;

        v1_next = rdy1 ? yuv.valid : v1_reg;
        v2_next = rdy2 ? v1_reg    : v2_reg;
        v3_next = rdy3 ? v2_reg    : v3_reg;
        v4_next = rdy4 ? v3_reg    : v4_reg;

        adv.sum_load   = rdy3;
        adv.clamp_load = rdy4;
    end

    assign yuv.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: center chroma. Values stay within -128..127.
    // ------------------------------------------------------------------
    always_comb
    begin
        u_s1_next = $signed({1'b0, yuv.data.chroma_blue}) - CHROMA_MID;
        v_s1_next = $signed({1'b0, yuv.data.chroma_red})  - CHROMA_MID;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            y0_s1_reg <= yuv.data.luma_first;
            y1_s1_reg <= yuv.data.luma_second;
            u_s1_reg  <= u_s1_next;
            v_s1_reg  <= v_s1_next;
            fe_s1_reg <= yuv.data.frame_end_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: one small multiplier per chroma term, coefficient times
    // centered chroma. The exact product always fits in PROD_W.
    // ------------------------------------------------------------------
    always_comb
    begin
        prod_rv_next = PROD_W'($signed({1'b0, K_RV})) * PROD_W'(v_s1_reg);
        prod_gu_next = PROD_W'($signed({1'b0, K_GU})) * PROD_W'(u_s1_reg);
        prod_gv_next = PROD_W'($signed({1'b0, K_GV})) * PROD_W'(v_s1_reg);
        prod_bu_next = PROD_W'($signed({1'b0, K_BU})) * PROD_W'(u_s1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            y0_s2_reg   <= y0_s1_reg;
            y1_s2_reg   <= y1_s1_reg;
            prod_rv_reg <= prod_rv_next;
            prod_gu_reg <= prod_gu_next;
            prod_gv_reg <= prod_gv_next;
            prod_bu_reg <= prod_bu_next;
            fe_s2_reg   <= fe_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 and 4: per-pixel sum, then floor and saturate.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rdy3)
            fe_s3_reg <= fe_s2_reg;
        if (rdy4)
            fe_s4_reg <= fe_s3_reg;
    end

    y2r_pixel u_pixel_first (
        .clk     (clk),
        .adv     (adv),
        .luma    (y0_s2_reg),
        .prod_rv (prod_rv_reg),
        .prod_gu (prod_gu_reg),
        .prod_gv (prod_gv_reg),
        .prod_bu (prod_bu_reg),
        .red     (rgb.data.red_first),
        .green   (rgb.data.green_first),
        .blue    (rgb.data.blue_first)
    );

    y2r_pixel u_pixel_second (
        .clk     (clk),
        .adv     (adv),
        .luma    (y1_s2_reg),
        .prod_rv (prod_rv_reg),
        .prod_gu (prod_gu_reg),
        .prod_gv (prod_gv_reg),
        .prod_bu (prod_bu_reg),
        .red     (rgb.data.red_second),
        .green   (rgb.data.green_second),
        .blue    (rgb.data.blue_second)
    );

    // Stage 4 is the output register.
    assign rgb.data.frame_end_out = fe_s4_reg;
    assign rgb.valid              = v4_reg;

endmodule

>>> design/y2r_checker.sv
// ----------------------------------------------------------------------------
// y2r_checker: port-level checks for the YUYV to RGB888 converter
// Watch the request handshakes and the pipeline timing seen at the ports.
// ----------------------------------------------------------------------------
module y2r_checker
    import y2r_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input y2r_rgb_t out_data
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid && !out_ready) && $past(rst_n) |-> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // With the output free, the whole pipeline can advance.
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output was ready");

    // A request that meets no stall passes stages 1 to 4 and reaches the output.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_valid && in_ready, 4) &&
        $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3) &&
        $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4)
        |-> out_valid)
        else $error("result missing after pipeline latency");

    // No result appears the cycle after reset is released.
    a_reset_empty: assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule

bind yuyv_to_rgb24_converter y2r_checker u_y2r_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (yuv.valid),
    .in_ready  (yuv.ready),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .out_data  (rgb.data)
);

>>> dv/yuyv_to_rgb24_converter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb24_converter_test: self-checking bench for the YUYV converter
// Sends directed corner words and then random YUYV words through the request
// channel. Both ends idle and stall at random. Every RGB pair that comes out
// is checked channel by channel against a fixed-point BT.601 predictor that
// runs in the bench.
// ----------------------------------------------------------------------------
module yuyv_to_rgb24_converter_test
    import y2r_pkg::*;
();

    // Chroma samples are offset binary around this value.
    localparam longint CHROMA_BIAS = 128;
    localparam longint PIXEL_MAX   = 255;
    localparam int     REPORT_MAX  = 10;

    // Q(F) coefficients, rounded half up from the three-decimal values.
    localparam longint Q_ONE   = longint'(1) << COEF_FRAC_BITS;
    localparam longint K_RED_V = (1402 * Q_ONE + 500) / 1000;
    localparam longint K_GRN_U = (344 * Q_ONE + 500) / 1000;
    localparam longint K_GRN_V = (714 * Q_ONE + 500) / 1000;
    localparam longint K_BLU_U = (1772 * Q_ONE + 500) / 1000;

    logic clk;
    logic rst_n;

    y2r_yuv_if yuv_ch ();
    y2r_rgb_if rgb_ch ();

    yuyv_to_rgb24_converter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .yuv   (yuv_ch),
        .rgb   (rgb_ch)
    );

    // Words waiting to be sent, and RGB pairs predicted for accepted words.
    y2r_yuv_t yuyv_backlog[$];
    y2r_rgb_t expected_rgb[$];

    // Percent of cycles in which the sender idles / the receiver stalls.
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned mismatch_count;

    y2r_rgb_t want_rgb;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Floor a Q(F) sum to an integer and saturate it to one 8-bit channel.
    function automatic logic [7:0] saturate_channel(input longint acc);
        longint whole;
        if (acc < 0)
            return 8'd0;
        whole = acc >>> COEF_FRAC_BITS;
        if (whole > PIXEL_MAX)
            return 8'hFF;
        return whole[7:0];
    endfunction

    // Convert one YUYV word into the pair of RGB888 pixels that share chroma.
    function automatic y2r_rgb_t rgb_from_yuyv(input y2r_yuv_t w);
        longint u;
        longint v;
        longint y0q;
        longint y1q;
        y2r_rgb_t p;
        u   = longint'(w.chroma_blue) - CHROMA_BIAS;
        v   = longint'(w.chroma_red) - CHROMA_BIAS;
        y0q = longint'(w.luma_first) <<< COEF_FRAC_BITS;
        y1q = longint'(w.luma_second) <<< COEF_FRAC_BITS;
        p.red_first     = saturate_channel(y0q + K_RED_V * v);
        p.green_first   = saturate_channel(y0q - K_GRN_U * u - K_GRN_V * v);
        p.blue_first    = saturate_channel(y0q + K_BLU_U * u);
        p.red_second    = saturate_channel(y1q + K_RED_V * v);
        p.green_second  = saturate_channel(y1q - K_GRN_U * u - K_GRN_V * v);
        p.blue_second   = saturate_channel(y1q + K_BLU_U * u);
        p.frame_end_out = w.frame_end_in;
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Queue one YUYV word for the sender.
    task automatic add_word(input logic [7:0] y0, input logic [7:0] u,
                            input logic [7:0] y1, input logic [7:0] v,
                            input logic fe);
        y2r_yuv_t w;
        w.luma_first   = y0;
        w.chroma_blue  = u;
        w.luma_second  = y1;
        w.chroma_red   = v;
        w.frame_end_in = fe;
        yuyv_backlog.push_back(w);
    endtask

    // Bias a quarter of the samples toward the ends of the range so that
    // both saturation limits are hit often.
    function automatic logic [7:0] random_sample();
        if ($urandom_range(3) == 0)
            return $urandom_range(1) ? 8'hFF - 8'($urandom_range(3)) : 8'($urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    // Compare one channel of a result; report only the first few misses.
    task automatic check_channel(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("%0t mismatch on %s: expected %0d, got %0d",
                         $realtime, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driver: present backlog words on the request channel. A word stays on
    // the bus, unchanged, until the converter takes it; only then may the
    // next one (or an idle cycle) follow.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yuv_ch.valid <= 1'b0;
            yuv_ch.data  <= '0;
        end
        else
        begin
            // Predict the result of the request accepted at this edge.
            if (yuv_ch.valid && yuv_ch.ready)
                expected_rgb.push_back(rgb_from_yuyv(yuv_ch.data));

            // Advance only when the bus is free: nothing shown, or just taken.
            if (!yuv_ch.valid || yuv_ch.ready)
            begin
                if (yuyv_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    yuv_ch.valid <= 1'b1;
                    yuv_ch.data  <= yuyv_backlog.pop_front();
                end
                else
                begin
                    yuv_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stall the result channel at random and check every accepted
    // RGB pair against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_ch.ready <= 1'b0;
        end
        else
        begin
            rgb_ch.ready <= ($urandom_range(99) >= stall_pct);
            if (rgb_ch.valid && rgb_ch.ready)
            begin
                if (expected_rgb.size() == 0)
                begin
                    // A result that no request accounts for.
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t unexpected result %h", $realtime, rgb_ch.data);
                end
                else
                begin
                    want_rgb = expected_rgb.pop_front();
                    check_channel("red_first", want_rgb.red_first, rgb_ch.data.red_first);
                    check_channel("green_first", want_rgb.green_first,
                                  rgb_ch.data.green_first);
                    check_channel("blue_first", want_rgb.blue_first, rgb_ch.data.blue_first);
                    check_channel("red_second", want_rgb.red_second, rgb_ch.data.red_second);
                    check_channel("green_second", want_rgb.green_second,
                                  rgb_ch.data.green_second);
                    check_channel("blue_second", want_rgb.blue_second,
                                  rgb_ch.data.blue_second);
                    check_channel("frame_end_out", 8'(want_rgb.frame_end_out),
                                  8'(rgb_ch.data.frame_end_out));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, then four phases of traffic with different idle and
    // stall rates. Between phases the sender holds off until every predicted
    // pair has come back, so the pipeline drains completely each time.
    // ------------------------------------------------------------------------
    initial
    begin
        int phase_idx;
        int unsigned word_count;

        rst_n          = 1'b0;
        idle_pct       = 0;
        stall_pct      = 0;
        mismatch_count = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            case (phase_idx)
                0:
                begin
                    // Full rate on both ends.
                    idle_pct   = 0;
                    stall_pct  = 0;
                    word_count = 150;
                end
                1:
                begin
                    idle_pct   = 65;
                    stall_pct  = 0;
                    word_count = 170;
                end
                2:
                begin
                    idle_pct   = 0;
                    stall_pct  = 65;
                    word_count = 170;
                end
                default:
                begin
                    idle_pct   = 28;
                    stall_pct  = 28;
                    word_count = 160;
                end
            endcase

            if (phase_idx == 0)
            begin
                // All-zero and all-one words.
                add_word(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
                add_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
                // Neutral chroma: RGB equals luma, at both luma extremes.
                add_word(8'h00, 8'h80, 8'hFF, 8'h80, 1'b0);
                add_word(8'hFF, 8'h80, 8'h00, 8'h80, 1'b1);
                add_word(8'h7F, 8'h80, 8'h80, 8'h80, 1'b0);
                // Chroma corners against dark and bright luma: red and blue
                // overflow above 255, green and blue go negative.
                add_word(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
                add_word(8'h00, 8'h00, 8'hFF, 8'h00, 1'b0);
                add_word(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0);
                add_word(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0);
                add_word(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1);
                add_word(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0);
                // Chroma one step off neutral in each direction.
                add_word(8'h80, 8'h7F, 8'h80, 8'h81, 1'b0);
                add_word(8'h80, 8'h81, 8'h80, 8'h7F, 1'b0);
                // Mid luma with strong chroma: saturation right at the edge.
                add_word(8'hB4, 8'hFF, 8'h4C, 8'h00, 1'b0);
                add_word(8'h4C, 8'h00, 8'hB4, 8'hFF, 1'b0);
                add_word(8'h01, 8'h01, 8'hFE, 8'hFE, 1'b1);
                // Alternating bit patterns across every field.
                add_word(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0);
                add_word(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b1);
            end

            repeat (word_count)
                add_word(random_sample(), random_sample(), random_sample(),
                         random_sample(), ($urandom_range(15) == 0));

            // Hold off until the backlog is sent and every pair is back.
            while (yuyv_backlog.size() != 0 || yuv_ch.valid || expected_rgb.size() != 0)
                @(negedge clk);
        end

        // Idle on before the verdict so that any stray result shows up.
        repeat (12) @(negedge clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run as a failure if the sequence has not finished in time.
    // ------------------------------------------------------------------------
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
design/y2r_pkg.sv
design/y2r_yuv_if.sv
design/y2r_rgb_if.sv
design/y2r_pixel.sv
design/yuyv_to_rgb24_converter.sv
design/y2r_checker.sv
dv/yuyv_to_rgb24_converter_test.sv
